/* src/stip_pkg.sv */
// Shared types, character codes and digit classification for the string-to-integer parser.
`default_nettype none

package stip_pkg;

    typedef logic [7:0] t_char;
    typedef logic [5:0] t_base;
    typedef logic [5:0] t_weight;

    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_X_LO  = 8'h78;
    localparam t_char CH_X_UP  = 8'h58;
    localparam t_char CH_SPACE = 8'h20;

    localparam t_base BASE_AUTO = 6'd0;
    localparam t_base BASE_MIN  = 6'd2;
    localparam t_base BASE_OCT  = 6'd8;
    localparam t_base BASE_DEC  = 6'd10;
    localparam t_base BASE_HEX  = 6'd16;
    localparam t_base BASE_MAX  = 6'd36;

    // Weight of a byte that is no alphanumeric; above every legal base.
    localparam t_weight WEIGHT_NONE = 6'd63;

    // Space, TAB, LF, VT, FF, CR.
    function automatic logic is_white(input t_char c);
        return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
    endfunction

    // Digit value 0..35 for 0-9, a-z, A-Z; WEIGHT_NONE otherwise.
    function automatic t_weight char_weight(input t_char c);
        t_weight w;
        if (c inside {[8'h30:8'h39]}) begin
            w = 6'(c - 8'h30);
        end else if (c inside {[8'h61:8'h7A]}) begin
            w = 6'(c - 8'h57);
        end else if (c inside {[8'h41:8'h5A]}) begin
            w = 6'(c - 8'h37);
        end else begin
            w = WEIGHT_NONE;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* src/string_to_integer_parser_unit.sv */
// Top level of the streaming string-to-integer parser (strtoull style).
//
// Usage:
//   Text enters on the s_axis channel, one byte per transaction in s_axis_tdata.
//   s_axis_tuser marks the first byte of a new string; a string in progress is
//   dropped when a new start arrives. Bytes before the first start are ignored.
//   Each string yields one result transaction on m_axis when its first
//   non-digit byte (the terminating 0 included) is taken: the value modulo
//   2^64 (negated for a leading '-'), the sign, a digits-found flag and the
//   count of bytes up to the last converted digit. Later bytes are ignored
//   until the next start.
//   The base register is written through i_cfg_we / i_cfg_wdata: 0 selects
//   auto-detection (0x -> 16, leading 0 -> 8, else 10); 2..36 is the base.
// Timing:
//   One byte per clock sustained. The result is loaded into the output register
//   at the edge that takes the ending byte, so m_axis_tvalid rises in the
//   following cycle. The per-byte multiply-add (64 by 6 bits) is the only
//   multiplier in the loop.
//   When m_axis_tready is low with a result waiting, s_axis_tready drops and
//   the input stalls until the result is taken; it then resumes at once.
// Reset: synchronous, active low; parser idle, base register 10, no result.
`default_nettype none

module string_to_integer_parser_unit #(
    parameter int COUNT_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Base register write
    input  wire                  i_cfg_we,
    input  wire  [5:0]           i_cfg_wdata,
    // Character stream
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [7:0]           s_axis_tdata,   // [7:0] character
    input  wire                  s_axis_tuser,   // [0] start_flag
    // Result stream
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // [63:0] value, [64] negative, [65] digits_found,
    // [65+COUNT_BITS:66] consumed_count, zero padding above
    output logic [((66 + COUNT_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int OUT_BITS = 66 + COUNT_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int PAD_W    = OUT_W - OUT_BITS;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS
    } t_phase;

    // Parser state
    t_phase                  r_phase,   n_phase;
    logic [63:0]             r_acc,     n_acc;
    logic                    r_sign,    n_sign;
    stip_pkg::t_base         r_eb,      n_eb;
    logic [COUNT_BITS-1:0]   r_cc,      n_cc;
    logic [COUNT_BITS-1:0]   r_ldc,     n_ldc;
    stip_pkg::t_base         r_base;

    // Result register
    logic                    r_out_valid;
    logic [63:0]             r_out_value,  n_out_value;
    logic                    r_out_neg;
    logic                    r_out_any,    n_out_any;
    logic [COUNT_BITS-1:0]   r_out_count,  n_out_count;
    logic                    n_emit;

    logic                    w_accept;
    stip_pkg::t_char         w_c;
    stip_pkg::t_weight       w_weight;
    logic                    w_white;
    logic                    w_is_sign;
    logic                    w_first;
    stip_pkg::t_base         w_first_base;
    stip_pkg::t_base         w_mul_base;
    logic [63:0]             w_acc_src;
    logic [63:0]             w_prod;
    logic [63:0]             w_mac;
    logic                    w_digit_ok;

    // Working copies after a possible start
    t_phase                  w_phase;
    logic [63:0]             w_acc;
    logic                    w_sign;
    stip_pkg::t_base         w_eb;
    logic [COUNT_BITS-1:0]   w_cc;
    logic [COUNT_BITS-1:0]   w_ldc;
    logic [COUNT_BITS-1:0]   w_cc_inc;

    // Accept a byte whenever the result register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_c       = s_axis_tdata;
    assign w_weight  = stip_pkg::char_weight(w_c);
    assign w_white   = stip_pkg::is_white(w_c);
    assign w_is_sign = (w_c == stip_pkg::CH_MINUS) || (w_c == stip_pkg::CH_PLUS);

    // A start wipes the string state before the byte is looked at
    always_comb begin
        if (s_axis_tuser) begin
            w_phase = PH_LEAD;
            w_acc   = '0;
            w_sign  = 1'b0;
            w_eb    = '0;
            w_cc    = '0;
            w_ldc   = '0;
        end else begin
            w_phase = r_phase;
            w_acc   = r_acc;
            w_sign  = r_sign;
            w_eb    = r_eb;
            w_cc    = r_cc;
            w_ldc   = r_ldc;
        end
    end

    // Saturating byte count including this byte
    assign w_cc_inc = (w_cc == {COUNT_BITS{1'b1}}) ? w_cc : w_cc + COUNT_BITS'(1);

    // First byte of the number proper: after whitespace and sign
    assign w_first = (w_phase == PH_SIGNED) ||
                     ((w_phase == PH_LEAD) && !w_white && !w_is_sign);
    assign w_first_base = (r_base == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC : r_base;

    // One shared multiply-add: acc * base + digit
    always_comb begin
        if (w_first) begin
            w_mul_base = w_first_base;
        end else if (w_phase == PH_HEXPFX) begin
            w_mul_base = stip_pkg::BASE_HEX;
        end else begin
            w_mul_base = w_eb;
        end
    end
    assign w_acc_src  = w_first ? 64'd0 : w_acc;
    assign w_prod     = w_acc_src * {58'd0, w_mul_base};
    assign w_mac      = w_prod + {58'd0, w_weight};
    assign w_digit_ok = (w_mul_base >= stip_pkg::BASE_MIN) &&
                        (w_mul_base <= stip_pkg::BASE_MAX) &&
                        (w_weight < w_mul_base);

    // Per-byte next state and result
    always_comb begin
        n_phase     = w_phase;
        n_acc       = w_acc;
        n_sign      = w_sign;
        n_eb        = w_eb;
        n_cc        = w_cc;
        n_ldc       = w_ldc;
        n_emit      = 1'b0;
        n_out_any   = 1'b0;
        n_out_value = '0;
        n_out_count = '0;

        if (w_phase != PH_IDLE) begin
            n_cc = w_cc_inc;
            if (w_first) begin
                n_acc = '0;
                if ((w_c == stip_pkg::CH_ZERO) && ((r_base == stip_pkg::BASE_AUTO) ||
                                                   (r_base == stip_pkg::BASE_HEX))) begin
                    n_eb    = (r_base == stip_pkg::BASE_HEX) ? stip_pkg::BASE_HEX
                                                             : stip_pkg::BASE_OCT;
                    n_ldc   = w_cc_inc;
                    n_phase = PH_ZERO;
                end else begin
                    n_eb = w_first_base;
                    if (w_digit_ok) begin
                        n_acc   = w_mac;
                        n_ldc   = w_cc_inc;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_emit    = 1'b1;
                        n_out_any = 1'b0;
                    end
                end
            end else begin
                case (w_phase)
                    PH_LEAD: begin
                        // Only whitespace or a sign lands here
                        if (w_is_sign) begin
                            n_sign  = (w_c == stip_pkg::CH_MINUS);
                            n_phase = PH_SIGNED;
                        end
                    end
                    PH_ZERO: begin
                        if ((w_c == stip_pkg::CH_X_LO) || (w_c == stip_pkg::CH_X_UP)) begin
                            n_eb    = stip_pkg::BASE_HEX;
                            n_phase = PH_HEXPFX;
                        end else if (w_digit_ok) begin
                            n_acc   = w_mac;
                            n_ldc   = w_cc_inc;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_emit    = 1'b1;
                            n_out_any = 1'b1;
                        end
                    end
                    PH_HEXPFX, PH_DIGITS: begin
                        if (w_digit_ok) begin
                            n_acc   = w_mac;
                            n_ldc   = w_cc_inc;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_emit    = 1'b1;
                            n_out_any = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = w_phase;
                    end
                endcase
            end
        end

        if (n_emit) begin
            n_phase     = PH_IDLE;
            n_out_value = n_out_any ? (w_sign ? (64'd0 - w_acc) : w_acc) : 64'd0;
            n_out_count = n_out_any ? w_ldc : '0;
        end
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_sign      <= 1'b0;
            r_eb        <= '0;
            r_cc        <= '0;
            r_ldc       <= '0;
            r_base      <= stip_pkg::BASE_DEC;
            r_out_valid <= 1'b0;
            r_out_value <= '0;
            r_out_neg   <= 1'b0;
            r_out_any   <= 1'b0;
            r_out_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_sign  <= n_sign;
                r_eb    <= n_eb;
                r_cc    <= n_cc;
                r_ldc   <= n_ldc;
            end
            if (w_accept && n_emit) begin
                r_out_valid <= 1'b1;
                r_out_value <= n_out_value;
                r_out_neg   <= w_sign;
                r_out_any   <= n_out_any;
                r_out_count <= n_out_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    generate
        if (PAD_W > 0) begin : g_pad
            assign m_axis_tdata = {{PAD_W{1'b0}}, r_out_count, r_out_any, r_out_neg,
                                   r_out_value};
        end else begin : g_nopad
            assign m_axis_tdata = {r_out_count, r_out_any, r_out_neg, r_out_value};
        end
    endgenerate

    // A result without digits carries a zero value and a zero count
    a_nodigit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_any) |-> ((r_out_value == 64'd0) && (r_out_count == '0)))
        else $error("no-digit result with nonzero value or count");

    // Bytes taken while idle with no start never create a result
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_phase == PH_IDLE) && !s_axis_tuser && !r_out_valid)
            |=> !r_out_valid)
        else $error("result produced from an ignored byte");

    // Digit phase always runs on a legal base
    a_digit_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGITS) |-> ((r_eb >= stip_pkg::BASE_MIN) &&
                                    (r_eb <= stip_pkg::BASE_MAX)))
        else $error("digit phase with illegal base");

    // The last digit never lies beyond the bytes counted so far
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_ldc <= r_cc))
        else $error("last digit count ahead of byte count");

endmodule

`default_nettype wire
